@@ hdl/bpa_pkg.sv @@
// Shared types and constants for the buddy page allocator.
// Used by bpa_page_store and buddy_page_allocator_core; no dependencies.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int PAGE_SLOTS   = 4096;
    localparam int PAGE_W       = 12;
    localparam int LINK_W       = 13;
    localparam int ORDER_LEVELS = 11;
    localparam int ORD_W        = 4;
    localparam int CNT_W        = 13;
    localparam int CFG_W        = 13;

    // Link value that marks an empty list or the end of a list
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(PAGE_SLOTS);
    localparam logic [ORD_W-1:0]  MAX_ORD  = ORD_W'(ORDER_LEVELS - 1);

    // Configuration register indexes
    localparam logic CFG_POOL_FIRST = 1'b0;
    localparam logic CFG_POOL_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NOP   = 2'd3
    } bpa_op_t;

    typedef struct packed {
        bpa_op_t           opcode;
        logic [ORD_W-1:0]  block_order;
        logic [PAGE_W-1:0] page_index;
    } bpa_cmd_t;

    typedef struct packed {
        logic              status;
        logic [PAGE_W-1:0] result_page;
        logic [ORD_W-1:0]  result_order;
    } bpa_result_t;

    // Write controls into the page store, one port per array
    typedef struct packed {
        logic              listed_we;
        logic [PAGE_W-1:0] listed_addr;
        logic              listed_val;
        logic              ord_we;
        logic [PAGE_W-1:0] ord_addr;
        logic [ORD_W-1:0]  ord_val;
        logic              next_we;
        logic [PAGE_W-1:0] next_addr;
        logic [LINK_W-1:0] next_val;
        logic              prev_we;
        logic [PAGE_W-1:0] prev_addr;
        logic [LINK_W-1:0] prev_val;
    } bpa_wr_t;

    // Registered read of one page descriptor
    typedef struct packed {
        logic              listed;
        logic [ORD_W-1:0]  ord;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } bpa_rd_t;

endpackage

@@ hdl/bpa_page_store.sv @@
// Per-page descriptor memories: listed flag, order, next and prev links.
// Depends on bpa_pkg. One write port per array, one shared read address.
`timescale 1ns / 1ps

module bpa_page_store
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic [PAGE_W-1:0] rd_addr,
    input  bpa_wr_t           wr,
    output bpa_rd_t           rd
);

    logic              listed_mem [PAGE_SLOTS];
    logic [ORD_W-1:0]  ord_mem    [PAGE_SLOTS];
    logic [LINK_W-1:0] next_mem   [PAGE_SLOTS];
    logic [LINK_W-1:0] prev_mem   [PAGE_SLOTS];

    // Writes
    always_ff @(posedge clk)
    begin
        if (wr.listed_we)
        begin
            listed_mem[wr.listed_addr] <= wr.listed_val;
        end
        if (wr.ord_we)
        begin
            ord_mem[wr.ord_addr] <= wr.ord_val;
        end
        if (wr.next_we)
        begin
            next_mem[wr.next_addr] <= wr.next_val;
        end
        if (wr.prev_we)
        begin
            prev_mem[wr.prev_addr] <= wr.prev_val;
        end
    end

    // Registered read, all arrays at one address
    always_ff @(posedge clk)
    begin
        rd.listed <= listed_mem[rd_addr];
        rd.ord    <= ord_mem[rd_addr];
        rd.next   <= next_mem[rd_addr];
        rd.prev   <= prev_mem[rd_addr];
    end

endmodule

@@ hdl/buddy_page_allocator_core.sv @@
// Buddy page allocator top level: command sequencer, free-list heads/tails
// and configuration. Depends on bpa_pkg and bpa_page_store.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; its one result
// appears on result with done high for exactly one cycle and must be taken
// then. All list work runs through a page store with one shared read
// address: an unlink reads the page, then fixes its neighbours; an insert
// then writes the page and, if the list held one, its old end. Alloc scans
// the orders upward, unlinks the block and inserts each split half inside
// the pool; free tests the buddy per merge level, then inserts the block.
// Init first clears the per-page listed flags, then carves the pool. After
// reset the same clearing pass runs with busy high before the first
// command is taken; configuration writes are taken at any time.
module buddy_page_allocator_core
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bpa_cmd_t          cmd,
    output logic              done,
    output bpa_result_t       result,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CARVE,
        S_SCAN,
        S_SPLIT,
        S_FCHK,
        S_FRD,
        S_FTST,
        S_URD,
        S_UACT,
        S_W1,
        S_W2,
        S_FIN
    } state_t;

    state_t            state_reg;
    state_t            ret_reg;
    logic [PAGE_W-1:0] clr_reg;
    logic              init_pend_reg;
    logic [PAGE_W-1:0] p_reg;
    logic [ORD_W-1:0]  o_reg;
    logic              front_reg;
    logic              ins_reg;
    logic [LINK_W-1:0] lnk_reg;
    logic [LINK_W-1:0] cur_reg;
    logic [ORD_W-1:0]  k_reg;
    logic [ORD_W-1:0]  ord_reg;
    logic [PAGE_W-1:0] first_reg;
    logic [CFG_W-1:0]  count_reg;
    logic [LINK_W-1:0] head_reg [ORDER_LEVELS];
    logic [LINK_W-1:0] tail_reg [ORDER_LEVELS];
    logic [CNT_W-1:0]  fcnt_reg [ORDER_LEVELS];
    logic              done_reg;
    bpa_result_t       res_reg;

    bpa_wr_t           wr;
    bpa_rd_t           rd;

    logic              accept;
    logic [LINK_W:0]   end_sum;
    logic [LINK_W-1:0] end_pg;
    logic              merge;
    logic              unl_en;
    logic [ORD_W-1:0]  un_o;
    logic [PAGE_W-1:0] fb;
    logic              fb_out;
    logic [ORD_W-1:0]  kn;
    logic [LINK_W-1:0] sb;
    logic [ORD_W-1:0]  carve_ord;
    logic [LINK_W:0]   carve_sum;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    bpa_page_store u_store (
        .clk     (clk),
        .rd_addr (p_reg),
        .wr      (wr),
        .rd      (rd)
    );

    // Pool end, saturated to the page count
    assign end_sum = (LINK_W+1)'(first_reg) + (LINK_W+1)'(count_reg);
    assign end_pg  = (end_sum > (LINK_W+1)'(PAGE_SLOTS)) ? NIL_LINK : end_sum[LINK_W-1:0];

    // Unlink of the page read at p_reg
    assign merge  = rd.listed && (rd.ord == k_reg);
    assign unl_en = ((state_reg == S_UACT) && rd.listed) || ((state_reg == S_FTST) && merge);
    assign un_o   = rd.ord;

    // Buddy of the current free block
    assign fb     = cur_reg[PAGE_W-1:0] ^ (PAGE_W'(1) << k_reg);
    assign fb_out = (fb < first_reg) || ({1'b0, fb} >= end_pg);

    // Upper half when splitting one order down
    assign kn = k_reg - ORD_W'(1);
    assign sb = {1'b0, cur_reg[PAGE_W-1:0]} + (LINK_W'(1) << kn);

    // Largest aligned block that fits at the carve cursor
    always_comb
    begin
        carve_ord = '0;
        carve_sum = '0;
        for (int i = 1; i < ORDER_LEVELS; i++)
        begin
            carve_sum = (LINK_W+1)'(cur_reg) + ((LINK_W+1)'(1) << i);
            if (((cur_reg & ((LINK_W'(1) << i) - LINK_W'(1))) == '0)
                && (carve_sum <= (LINK_W+1)'(end_pg)))
            begin
                carve_ord = ORD_W'(i);
            end
        end
    end

    // Page store write controls
    always_comb
    begin
        wr = '0;
        if (state_reg == S_CLEAR)
        begin
            wr.listed_we   = 1'b1;
            wr.listed_addr = clr_reg;
            wr.listed_val  = 1'b0;
        end
        if (unl_en)
        begin
            wr.listed_we   = 1'b1;
            wr.listed_addr = p_reg;
            wr.listed_val  = 1'b0;
            wr.next_we     = !rd.prev[LINK_W-1];
            wr.next_addr   = rd.prev[PAGE_W-1:0];
            wr.next_val    = rd.next;
            wr.prev_we     = !rd.next[LINK_W-1];
            wr.prev_addr   = rd.next[PAGE_W-1:0];
            wr.prev_val    = rd.prev;
        end
        if (state_reg == S_W1)
        begin
            wr.listed_we   = 1'b1;
            wr.listed_addr = p_reg;
            wr.listed_val  = 1'b1;
            wr.ord_we      = 1'b1;
            wr.ord_addr    = p_reg;
            wr.ord_val     = o_reg;
            wr.next_we     = 1'b1;
            wr.next_addr   = p_reg;
            wr.prev_we     = 1'b1;
            wr.prev_addr   = p_reg;
            if (front_reg)
            begin
                wr.next_val = head_reg[o_reg];
                wr.prev_val = NIL_LINK;
            end
            else
            begin
                wr.next_val = NIL_LINK;
                wr.prev_val = tail_reg[o_reg];
            end
        end
        if (state_reg == S_W2)
        begin
            if (front_reg)
            begin
                wr.prev_we   = 1'b1;
                wr.prev_addr = lnk_reg[PAGE_W-1:0];
                wr.prev_val  = {1'b0, p_reg};
            end
            else
            begin
                wr.next_we   = 1'b1;
                wr.next_addr = lnk_reg[PAGE_W-1:0];
                wr.next_val  = {1'b0, p_reg};
            end
        end
    end

    // Sequencer, list registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            clr_reg       <= '0;
            init_pend_reg <= 1'b0;
            p_reg         <= '0;
            o_reg         <= '0;
            front_reg     <= 1'b0;
            ins_reg       <= 1'b0;
            lnk_reg       <= NIL_LINK;
            cur_reg       <= '0;
            k_reg         <= '0;
            ord_reg       <= '0;
            first_reg     <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            res_reg       <= '0;
            for (int i = 0; i < ORDER_LEVELS; i++)
            begin
                head_reg[i] <= NIL_LINK;
                tail_reg[i] <= NIL_LINK;
                fcnt_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;

            // Configuration writes
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_POOL_FIRST: first_reg <= cfg_data[PAGE_W-1:0];
                    CFG_POOL_COUNT: count_reg <= cfg_data;
                    default: ;
                endcase
            end

            // List bookkeeping of an unlink
            if (unl_en)
            begin
                if (rd.prev[LINK_W-1])
                begin
                    head_reg[un_o] <= rd.next;
                end
                if (rd.next[LINK_W-1])
                begin
                    tail_reg[un_o] <= rd.prev;
                end
                if (fcnt_reg[un_o] != '0)
                begin
                    fcnt_reg[un_o] <= fcnt_reg[un_o] - CNT_W'(1);
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ord_reg <= cmd.block_order;
                        k_reg   <= cmd.block_order;
                        unique case (cmd.opcode)
                            OP_ALLOC:
                            begin
                                if (cmd.block_order > MAX_ORD)
                                begin
                                    done_reg <= 1'b1;
                                    res_reg  <= '{status: 1'b1, result_page: '0,
                                                  result_order: '0};
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            OP_FREE:
                            begin
                                if (cmd.block_order > MAX_ORD)
                                begin
                                    done_reg <= 1'b1;
                                    res_reg  <= '0;
                                end
                                else
                                begin
                                    cur_reg   <= {1'b0, cmd.page_index};
                                    p_reg     <= cmd.page_index;
                                    ins_reg   <= 1'b0;
                                    ret_reg   <= S_FCHK;
                                    state_reg <= S_URD;
                                end
                            end
                            OP_INIT:
                            begin
                                clr_reg       <= '0;
                                init_pend_reg <= 1'b1;
                                state_reg     <= S_CLEAR;
                                for (int i = 0; i < ORDER_LEVELS; i++)
                                begin
                                    head_reg[i] <= NIL_LINK;
                                    tail_reg[i] <= NIL_LINK;
                                    fcnt_reg[i] <= '0;
                                end
                            end
                            OP_NOP:
                            begin
                                done_reg <= 1'b1;
                                res_reg  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end

                // Sweep of the listed flags
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + PAGE_W'(1);
                    if (clr_reg == '1)
                    begin
                        cur_reg       <= {1'b0, first_reg};
                        init_pend_reg <= 1'b0;
                        state_reg     <= init_pend_reg ? S_CARVE : S_IDLE;
                    end
                end

                // Carve the pool into aligned blocks, appended at the back
                S_CARVE:
                begin
                    if (cur_reg < end_pg)
                    begin
                        p_reg     <= cur_reg[PAGE_W-1:0];
                        o_reg     <= carve_ord;
                        front_reg <= 1'b0;
                        ins_reg   <= 1'b1;
                        ret_reg   <= S_CARVE;
                        cur_reg   <= cur_reg + (LINK_W'(1) << carve_ord);
                        state_reg <= S_URD;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        res_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end

                // Alloc: one order per cycle
                S_SCAN:
                begin
                    if (!head_reg[k_reg][LINK_W-1])
                    begin
                        cur_reg   <= head_reg[k_reg];
                        p_reg     <= head_reg[k_reg][PAGE_W-1:0];
                        ins_reg   <= 1'b0;
                        ret_reg   <= S_SPLIT;
                        state_reg <= S_URD;
                    end
                    else if (k_reg == MAX_ORD)
                    begin
                        done_reg  <= 1'b1;
                        res_reg   <= '{status: 1'b1, result_page: '0, result_order: '0};
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg <= k_reg + ORD_W'(1);
                    end
                end

                // Alloc: split down, upper halves inside the pool go back
                S_SPLIT:
                begin
                    if (k_reg > ord_reg)
                    begin
                        k_reg <= kn;
                        if (sb < end_pg)
                        begin
                            p_reg     <= sb[PAGE_W-1:0];
                            o_reg     <= kn;
                            front_reg <= 1'b0;
                            ins_reg   <= 1'b1;
                            ret_reg   <= S_SPLIT;
                            state_reg <= S_URD;
                        end
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        res_reg   <= '{status: 1'b0, result_page: cur_reg[PAGE_W-1:0],
                                       result_order: ord_reg};
                        state_reg <= S_IDLE;
                    end
                end

                // Free: check the buddy, or insert at the front
                S_FCHK:
                begin
                    if ((k_reg != MAX_ORD) && !fb_out)
                    begin
                        p_reg     <= fb;
                        state_reg <= S_FRD;
                    end
                    else
                    begin
                        p_reg     <= cur_reg[PAGE_W-1:0];
                        o_reg     <= k_reg;
                        front_reg <= 1'b1;
                        ins_reg   <= 1'b1;
                        ret_reg   <= S_FIN;
                        state_reg <= S_URD;
                    end
                end

                S_FRD:
                begin
                    state_reg <= S_FTST;
                end

                // Free: merge if the buddy is a listed block of equal order
                S_FTST:
                begin
                    if (merge)
                    begin
                        if ({1'b0, p_reg} < cur_reg)
                        begin
                            cur_reg <= {1'b0, p_reg};
                        end
                        k_reg     <= k_reg + ORD_W'(1);
                        state_reg <= S_FCHK;
                    end
                    else
                    begin
                        p_reg     <= cur_reg[PAGE_W-1:0];
                        o_reg     <= k_reg;
                        front_reg <= 1'b1;
                        ins_reg   <= 1'b1;
                        ret_reg   <= S_FIN;
                        state_reg <= S_URD;
                    end
                end

                // Unlink p_reg, then optionally insert it
                S_URD:
                begin
                    state_reg <= S_UACT;
                end

                S_UACT:
                begin
                    state_reg <= ins_reg ? S_W1 : ret_reg;
                end

                S_W1:
                begin
                    fcnt_reg[o_reg] <= fcnt_reg[o_reg] + CNT_W'(1);
                    if (front_reg)
                    begin
                        lnk_reg         <= head_reg[o_reg];
                        head_reg[o_reg] <= {1'b0, p_reg};
                        if (head_reg[o_reg][LINK_W-1])
                        begin
                            tail_reg[o_reg] <= {1'b0, p_reg};
                        end
                        state_reg <= head_reg[o_reg][LINK_W-1] ? ret_reg : S_W2;
                    end
                    else
                    begin
                        lnk_reg         <= tail_reg[o_reg];
                        tail_reg[o_reg] <= {1'b0, p_reg};
                        if (tail_reg[o_reg][LINK_W-1])
                        begin
                            head_reg[o_reg] <= {1'b0, p_reg};
                        end
                        state_reg <= tail_reg[o_reg][LINK_W-1] ? ret_reg : S_W2;
                    end
                end

                S_W2:
                begin
                    state_reg <= ret_reg;
                end

                S_FIN:
                begin
                    done_reg  <= 1'b1;
                    res_reg   <= '{status: 1'b0, result_page: cur_reg[PAGE_W-1:0],
                                   result_order: k_reg};
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Neighbor link fix-up only happens for a real neighbor
    a_w2_link: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_W2) |-> !lnk_reg[LINK_W-1])
        else $error("neighbor fix-up without a neighbor");

    // An accepted command is either in progress or answered next cycle
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done_reg))
        else $error("command dropped");

    // Out-of-memory beats carry no block
    a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.status) |->
            ((res_reg.result_page == '0) && (res_reg.result_order == '0)))
        else $error("failed alloc reports a block");

    // Scanned list has consistent head and tail
    a_scan_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |->
            ((k_reg <= MAX_ORD) &&
             (head_reg[k_reg][LINK_W-1] == tail_reg[k_reg][LINK_W-1])))
        else $error("free list head and tail disagree");

endmodule

@@ test/tb_buddy_page_allocator_core.sv @@
// Self-checking testbench for buddy_page_allocator_core: a directed table, then random
// alloc/free traffic over several pool settings, checked against a free-list predictor.
// Depends on bpa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_buddy_page_allocator_core;
    import bpa_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 200;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    bpa_cmd_t          cmd;
    logic              done;
    bpa_result_t       result;
    logic              cfg_wr_en;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    buddy_page_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock: 8 ns period
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Free-list shadow of the allocator
    // ------------------------------------------------------------------
    int unsigned shadow_first;
    int unsigned shadow_count;
    bit [3:0]    shadow_ord    [PAGE_SLOTS];
    bit          shadow_taken  [PAGE_SLOTS];
    bit          shadow_listed [PAGE_SLOTS];
    int unsigned shadow_next   [PAGE_SLOTS];
    int unsigned shadow_prev   [PAGE_SLOTS];
    int unsigned shadow_head   [ORDER_LEVELS];
    int unsigned shadow_tail   [ORDER_LEVELS];
    int unsigned shadow_cnt    [ORDER_LEVELS];

    function automatic int unsigned shadow_pool_end();
        int unsigned e;
        e = shadow_first + shadow_count;
        return (e > PAGE_SLOTS) ? PAGE_SLOTS : e;
    endfunction

    function automatic void shadow_unlink(int unsigned p);
        int unsigned o;
        int unsigned n;
        int unsigned v;
        if (p >= PAGE_SLOTS || !shadow_listed[p]) return;
        o = shadow_ord[p];
        if (o >= ORDER_LEVELS)
        begin
            shadow_listed[p] = 1'b0;
            return;
        end
        n = shadow_next[p];
        v = shadow_prev[p];
        if (v < PAGE_SLOTS) shadow_next[v] = n; else shadow_head[o] = n;
        if (n < PAGE_SLOTS) shadow_prev[n] = v; else shadow_tail[o] = v;
        if (shadow_cnt[o] > 0) shadow_cnt[o]--;
        shadow_listed[p] = 1'b0;
    endfunction

    // Mark p a free block of order o, link at front or back of its list
    function automatic void shadow_link(int unsigned o, int unsigned p, bit at_front);
        shadow_unlink(p);
        shadow_ord[p]   = o[3:0];
        shadow_taken[p] = 1'b0;
        if (at_front)
        begin
            shadow_prev[p] = PAGE_SLOTS;
            shadow_next[p] = shadow_head[o];
            if (shadow_head[o] < PAGE_SLOTS) shadow_prev[shadow_head[o]] = p;
            else shadow_tail[o] = p;
            shadow_head[o] = p;
        end
        else
        begin
            shadow_next[p] = PAGE_SLOTS;
            shadow_prev[p] = shadow_tail[o];
            if (shadow_tail[o] < PAGE_SLOTS) shadow_next[shadow_tail[o]] = p;
            else shadow_head[o] = p;
            shadow_tail[o] = p;
        end
        shadow_listed[p] = 1'b1;
        shadow_cnt[o]++;
    endfunction

    function automatic void shadow_reset();
        shadow_first = 0;
        shadow_count = 0;
        for (int i = 0; i < PAGE_SLOTS; i++)
        begin
            shadow_ord[i]    = '0;
            shadow_taken[i]  = 1'b0;
            shadow_listed[i] = 1'b0;
            shadow_next[i]   = 0;
            shadow_prev[i]   = 0;
        end
        for (int i = 0; i < ORDER_LEVELS; i++)
        begin
            shadow_head[i] = PAGE_SLOTS;
            shadow_tail[i] = PAGE_SLOTS;
            shadow_cnt[i]  = 0;
        end
    endfunction

    // Carve the pool into the largest aligned blocks
    function automatic void shadow_carve();
        int unsigned cur;
        int unsigned end_pg;
        int unsigned o;
        for (int i = 0; i < ORDER_LEVELS; i++)
        begin
            shadow_head[i] = PAGE_SLOTS;
            shadow_tail[i] = PAGE_SLOTS;
            shadow_cnt[i]  = 0;
        end
        for (int i = 0; i < PAGE_SLOTS; i++) shadow_listed[i] = 1'b0;
        end_pg = shadow_pool_end();
        cur    = shadow_first;
        while (cur < end_pg)
        begin
            o = ORDER_LEVELS - 1;
            while (o > 0)
            begin
                if ((cur & ((1 << o) - 1)) == 0 && cur + (1 << o) <= end_pg) break;
                o--;
            end
            shadow_link(o, cur, 1'b0);
            cur += (1 << o);
        end
    endfunction

    // Apply one command to the shadow and return the allocator's answer
    function automatic bpa_result_t shadow_apply(bpa_cmd_t c);
        bpa_result_t r;
        int unsigned ord;
        int unsigned k;
        int unsigned pg;
        int unsigned bud;
        int unsigned end_pg;
        r   = '0;
        ord = c.block_order;
        case (c.opcode)
            OP_ALLOC:
            begin
                k = ord;
                while (k < ORDER_LEVELS && shadow_head[k] >= PAGE_SLOTS) k++;
                if (ord >= ORDER_LEVELS || k >= ORDER_LEVELS)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    pg = shadow_head[k];
                    shadow_unlink(pg);
                    end_pg = shadow_pool_end();
                    while (k > ord)
                    begin
                        k--;
                        bud = pg + (1 << k);
                        if (bud < end_pg) shadow_link(k, bud, 1'b0);
                    end
                    shadow_ord[pg]   = ord[3:0];
                    shadow_taken[pg] = 1'b1;
                    r.result_page    = pg[PAGE_W-1:0];
                    r.result_order   = ord[3:0];
                end
            end
            OP_FREE:
            begin
                if (ord < ORDER_LEVELS)
                begin
                    k      = ord;
                    pg     = c.page_index;
                    end_pg = shadow_pool_end();
                    shadow_unlink(pg);
                    while (k < ORDER_LEVELS - 1)
                    begin
                        bud = pg ^ (1 << k);
                        if (bud < shadow_first || bud >= end_pg) break;
                        if (!shadow_listed[bud] || shadow_taken[bud] || shadow_ord[bud] != k)
                            break;
                        shadow_unlink(bud);
                        if (bud < pg) pg = bud;
                        k++;
                        shadow_ord[pg] = k[3:0];
                    end
                    shadow_link(k, pg, 1'b1);
                    r.result_page  = pg[PAGE_W-1:0];
                    r.result_order = k[3:0];
                end
            end
            OP_INIT:
            begin
                shadow_carve();
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    bpa_result_t pending_results[$];
    int          error_count;
    int          cycle_count;

    task automatic report(string what, int got, int want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        bpa_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report("unexpected result beat", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report("status", result.status, want.status);
                if (result.result_page !== want.result_page)
                    report("result_page", result.result_page, want.result_page);
                if (result.result_order !== want.result_order)
                    report("result_order", result.result_order, want.result_order);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_buddy_page_allocator_core: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [ORD_W-1:0]  ord;
    } held_block_t;

    typedef enum logic { ROW_CMD, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        bpa_cmd_t    c;
        logic        reg_idx;
        int unsigned reg_val;
        bit          known;
        bpa_result_t want;
    } dir_row_t;

    held_block_t held_blocks[$];
    dir_row_t    dir_rows[$];
    int          burst_left;

    function automatic bpa_cmd_t mk_cmd(bpa_op_t op, int unsigned o, int unsigned p);
        bpa_cmd_t c;
        c.opcode      = op;
        c.block_order = o[ORD_W-1:0];
        c.page_index  = p[PAGE_W-1:0];
        return c;
    endfunction

    function automatic void add_cmd(bpa_cmd_t c, bit known, bit st, int unsigned pg,
                                    int unsigned o);
        dir_row_t row;
        row.kind               = ROW_CMD;
        row.c                  = c;
        row.reg_idx            = CFG_POOL_FIRST;
        row.reg_val            = 0;
        row.known              = known;
        row.want.status        = st;
        row.want.result_page   = pg[PAGE_W-1:0];
        row.want.result_order  = o[ORD_W-1:0];
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic idx, int unsigned val);
        dir_row_t row;
        row.kind    = ROW_CFG;
        row.c       = '0;
        row.reg_idx = idx;
        row.reg_val = val;
        row.known   = 1'b0;
        row.want    = '0;
        dir_rows.push_back(row);
    endfunction

    // Send one command; the want argument overrides the shadow when known
    task automatic issue(bpa_cmd_t c, bit known, bpa_result_t want);
        int gap;
        bpa_result_t predicted;
        // bursts of back-to-back beats separated by random gaps
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
        end
        else
        begin
            gap = 0;
        end
        burst_left--;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        predicted = shadow_apply(c);
        pending_results.push_back(known ? want : predicted);
        if (c.opcode == OP_ALLOC && predicted.status == 1'b0)
            held_blocks.push_back('{predicted.result_page, predicted.result_order});
        if (c.opcode == OP_INIT)
            held_blocks.delete();
    endtask

    // Register write, only once the allocator has gone quiet
    task automatic write_reg(logic idx, int unsigned val);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_POOL_FIRST) shadow_first = val & 12'hFFF;
        else shadow_count = val & 13'h1FFF;
        burst_left = 0;
    endtask

    // Random command, mostly well-formed alloc/free pairs
    function automatic bpa_cmd_t pick_random();
        int unsigned sel;
        int unsigned idx;
        held_block_t hb;
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            if ($urandom_range(0, 19) == 0)
                return mk_cmd(OP_ALLOC, $urandom_range(11, 15), $urandom_range(0, 4095));
            if ($urandom_range(0, 3) == 0)
                return mk_cmd(OP_ALLOC, $urandom_range(5, 10), $urandom_range(0, 4095));
            return mk_cmd(OP_ALLOC, $urandom_range(0, 4), $urandom_range(0, 4095));
        end
        if (sel < 87 && held_blocks.size() != 0)
        begin
            idx = $urandom_range(0, held_blocks.size() - 1);
            hb  = held_blocks[idx];
            held_blocks.delete(idx);
            return mk_cmd(OP_FREE, hb.ord, hb.page);
        end
        if (sel < 97)
            return mk_cmd(OP_FREE, $urandom_range(0, 15), $urandom_range(0, 4095));
        if (sel < 99)
            return mk_cmd(OP_NOP, $urandom_range(0, 15), $urandom_range(0, 4095));
        return mk_cmd(OP_INIT, $urandom_range(0, 15), $urandom_range(0, 4095));
    endfunction

    initial
    begin
        int unsigned pool_cfg[6][2];
        bpa_result_t none;
        dir_row_t    row;

        pool_cfg = '{'{0, 4096}, '{4095, 1}, '{100, 4096}, '{37, 300},
                     '{0, 0}, '{2048, 2047}};
        none        = '0;
        error_count = 0;
        cycle_count = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_POOL_FIRST;
        cfg_data    = '0;
        shadow_reset();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows: empty pool after reset, then a full pool
        add_cmd(mk_cmd(OP_ALLOC, 0, 0), 1, 1'b1, 0, 0);
        add_cmd(mk_cmd(OP_ALLOC, 15, 4095), 1, 1'b1, 0, 0);
        add_cmd(mk_cmd(OP_FREE, 11, 4095), 1, 1'b0, 0, 0);
        add_cmd(mk_cmd(OP_NOP, 15, 4095), 1, 1'b0, 0, 0);
        add_cmd(mk_cmd(OP_INIT, 0, 0), 1, 1'b0, 0, 0);
        add_cmd(mk_cmd(OP_FREE, 0, 5), 0, 0, 0, 0);
        add_cfg(CFG_POOL_FIRST, 0);
        add_cfg(CFG_POOL_COUNT, 4096);
        add_cmd(mk_cmd(OP_INIT, 0, 0), 1, 1'b0, 0, 0);
        add_cmd(mk_cmd(OP_ALLOC, 10, 0), 1, 1'b0, 0, 10);
        add_cmd(mk_cmd(OP_ALLOC, 0, 0), 0, 0, 0, 0);
        add_cmd(mk_cmd(OP_FREE, 10, 0), 0, 0, 0, 0);
        add_cmd(mk_cmd(OP_FREE, 0, 1024), 0, 0, 0, 0);
        add_cmd(mk_cmd(OP_ALLOC, 10, 0), 0, 0, 0, 0);
        add_cmd(mk_cmd(OP_ALLOC, 10, 0), 0, 0, 0, 0);
        add_cmd(mk_cmd(OP_ALLOC, 10, 0), 0, 0, 0, 0);
        add_cmd(mk_cmd(OP_ALLOC, 10, 0), 0, 0, 0, 0);
        add_cmd(mk_cmd(OP_ALLOC, 10, 0), 0, 0, 0, 0);
        add_cmd(mk_cmd(OP_FREE, 0, 4095), 0, 0, 0, 0);
        add_cmd(mk_cmd(OP_FREE, 0, 4094), 0, 0, 0, 0);
        add_cmd(mk_cmd(OP_FREE, 0, 4094), 0, 0, 0, 0);
        add_cmd(mk_cmd(OP_FREE, 3, 2048), 0, 0, 0, 0);
        add_cmd(mk_cmd(OP_ALLOC, 1, 0), 0, 0, 0, 0);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) write_reg(row.reg_idx, row.reg_val);
            else issue(row.c, row.known, row.want);
        end

        // Random phases, each over its own pool setting
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_POOL_FIRST, pool_cfg[ph][0]);
            write_reg(CFG_POOL_COUNT, pool_cfg[ph][1]);
            issue(mk_cmd(OP_INIT, 0, 0), 0, none);
            for (int n = 0; n < 180; n++) issue(pick_random(), 0, none);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("tb_buddy_page_allocator_core: clean");
        else
            $display("tb_buddy_page_allocator_core: errors");
        $finish;
    end

endmodule
